// File: design/aema_pkg.sv
// Shared constants, field layouts and controller/datapath command types
// for the approximate-circuit error metric accumulator. No dependencies.
package aema_pkg;

    localparam int OUTPUT_BITS    = 16;
    localparam int MAX_INPUT_VARS = 16;

    localparam int WORD_W  = 16;
    localparam int DIFF_W  = 17;
    localparam int CNT_W   = 17;
    localparam int PROD_W  = 32;
    localparam int SUM_W   = 48;
    localparam int WSUM_W  = 33;
    localparam int MEAN_W  = 24;
    localparam int FRAC_W  = 17;
    localparam int NUM_W   = SUM_W + 8;
    localparam int QUO_W   = 24;
    localparam int STEP_W  = $clog2(QUO_W + 1);

    localparam int S_TDATA_W   = 3 * WORD_W;
    localparam int M_PAYLOAD_W = DIFF_W + WORD_W + MEAN_W + FRAC_W + 2 * CNT_W;
    localparam int M_TDATA_W   = ((M_PAYLOAD_W + 7) / 8) * 8;

    localparam logic [WORD_W-1:0] WORD_MASK = (OUTPUT_BITS >= WORD_W) ? {WORD_W{1'b1}}
        : WORD_W'((64'd1 << OUTPUT_BITS) - 64'd1);
    localparam logic [CNT_W-1:0] COUNT_LIMIT = (MAX_INPUT_VARS >= CNT_W) ? {CNT_W{1'b1}}
        : CNT_W'(64'd1 << MAX_INPUT_VARS);

    typedef enum logic [5:0] {
        S_RUN       = 6'b000001,
        S_MEAN_GO   = 6'b000010,
        S_MEAN_WAIT = 6'b000100,
        S_FRAC_GO   = 6'b001000,
        S_FRAC_WAIT = 6'b010000,
        S_SUMMARY   = 6'b100000
    } state_t;

    typedef struct packed {
        logic st1_load;
        logic acc_en;
        logic out_load_item;
        logic out_load_sum;
        logic div_start;
        logic div_sel_frac;
        logic cap_mean;
    } cmd_t;

    typedef struct packed {
        logic st1_last;
        logic div_done;
    } status_t;

endpackage

// File: design/aema_div.sv
// Shared restoring divider, one quotient bit per cycle, 24-bit saturating
// quotient. Uses aema_pkg.
module aema_div (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [aema_pkg::NUM_W-1:0] num,
    input  logic [aema_pkg::WSUM_W-1:0] den,
    output logic                       done,
    output logic [aema_pkg::QUO_W-1:0] quo
);
    import aema_pkg::*;

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [STEP_W-1:0]   cnt_reg, cnt_next;
    logic [WSUM_W-1:0]   rem_reg, rem_next;
    logic [WSUM_W-1:0]   den_reg, den_next;
    logic [QUO_W-1:0]    q_reg, q_next;
    logic [WSUM_W:0]     trial;
    logic [WSUM_W:0]     trial_sub;
    logic                fits;

    assign trial     = {rem_reg, q_reg[QUO_W-1]};
    assign trial_sub = trial - {1'b0, den_reg};
    assign fits      = trial >= {1'b0, den_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        q_next    = q_reg;
        if (start) begin
            den_next = den;
            if (den == '0) begin
                q_next    = '0;
                done_next = 1'b1;
            end else if ({1'b0, num[NUM_W-1:QUO_W]} >= den) begin
                q_next    = {QUO_W{1'b1}};
                done_next = 1'b1;
            end else begin
                rem_next  = {1'b0, num[NUM_W-1:QUO_W]};
                q_next    = num[QUO_W-1:0];
                cnt_next  = STEP_W'(QUO_W);
                busy_next = 1'b1;
            end
        end else if (busy_reg) begin
            rem_next = fits ? trial_sub[WSUM_W-1:0] : trial[WSUM_W-1:0];
            q_next   = {q_reg[QUO_W-2:0], fits};
            cnt_next = cnt_reg - STEP_W'(1);
            if (cnt_reg == STEP_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        den_reg <= den_next;
        q_reg   <= q_next;
    end

    assign done = done_reg;
    assign quo  = q_reg;

    // iteration count stays in range while busy
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (cnt_reg != '0 && cnt_reg <= STEP_W'(QUO_W)))
        else $error("divider step count out of range");
    // a new start never lands on a running division
    a_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> !start)
        else $error("divider restarted while busy");
    // done is a single-cycle pulse
    a_done_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |=> !done_reg)
        else $error("divider done held for more than one cycle");

endmodule

// File: design/aema_dp.sv
// Datapath: input stage with multiplier, run accumulators, divider operand
// select, output register. Uses aema_pkg and aema_div.
module aema_dp #(
    parameter int OUTPUT_BITS    = aema_pkg::OUTPUT_BITS,
    parameter int MAX_INPUT_VARS = aema_pkg::MAX_INPUT_VARS
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  aema_pkg::cmd_t                 cmd,
    output aema_pkg::status_t              status,
    input  logic [aema_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                           s_tlast,
    input  logic                           cfg_valid,
    input  logic                           cfg_data,
    output logic [aema_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                           m_tuser
);
    import aema_pkg::*;

    localparam logic [WORD_W-1:0] IN_MASK = (OUTPUT_BITS >= WORD_W) ? {WORD_W{1'b1}}
        : WORD_W'((64'd1 << OUTPUT_BITS) - 64'd1);
    localparam logic [CNT_W-1:0] CNT_LIMIT = (MAX_INPUT_VARS >= CNT_W) ? {CNT_W{1'b1}}
        : CNT_W'(64'd1 << MAX_INPUT_VARS);

    logic [WORD_W-1:0] in_exact, in_approx, in_weight, in_w;
    logic [DIFF_W-1:0] in_diff;
    logic [WORD_W-1:0] in_absd;

    logic              uniform_reg;
    logic [DIFF_W-1:0] st1_diff_reg;
    logic [WORD_W-1:0] st1_absd_reg;
    logic [PROD_W-1:0] st1_prod_reg;
    logic [WORD_W-1:0] st1_w_reg;
    logic              st1_last_reg;

    logic [CNT_W-1:0]  seen_reg, seen_next;
    logic [CNT_W-1:0]  wrong_reg, wrong_next;
    logic [WORD_W-1:0] worst_reg, worst_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [WSUM_W-1:0] wt_reg, wt_next;
    logic [SUM_W:0]    sum_add;
    logic [WSUM_W:0]   wt_add;

    logic [MEAN_W-1:0]      mean_reg;
    logic [M_PAYLOAD_W-1:0] out_data_reg;
    logic                   out_user_reg;

    logic [NUM_W-1:0]  div_num;
    logic [WSUM_W-1:0] div_den;
    logic              div_done;
    logic [QUO_W-1:0]  div_quo;

    assign in_exact  = s_tdata[WORD_W-1:0] & IN_MASK;
    assign in_approx = s_tdata[2*WORD_W-1:WORD_W] & IN_MASK;
    assign in_weight = s_tdata[3*WORD_W-1:2*WORD_W];
    assign in_w      = uniform_reg ? WORD_W'(1) : in_weight;
    assign in_diff   = {1'b0, in_approx} - {1'b0, in_exact};
    assign in_absd   = in_diff[DIFF_W-1] ? WORD_W'(-in_diff) : in_diff[WORD_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            uniform_reg <= 1'b1;
        end else if (cfg_valid) begin
            uniform_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.st1_load) begin
            st1_diff_reg <= in_diff;
            st1_absd_reg <= in_absd;
            st1_prod_reg <= in_w * in_absd;
            st1_w_reg    <= in_w;
            st1_last_reg <= s_tlast;
        end
    end

    assign sum_add = {1'b0, sum_reg} + (SUM_W + 1)'(st1_prod_reg);
    assign wt_add  = {1'b0, wt_reg} + (WSUM_W + 1)'(st1_w_reg);

    always_comb begin
        seen_next  = seen_reg;
        wrong_next = wrong_reg;
        worst_next = worst_reg;
        sum_next   = sum_reg;
        wt_next    = wt_reg;
        if (cmd.out_load_sum) begin
            seen_next  = '0;
            wrong_next = '0;
            worst_next = '0;
            sum_next   = '0;
            wt_next    = '0;
        end else if (cmd.acc_en) begin
            if (seen_reg < CNT_LIMIT) begin
                seen_next = seen_reg + CNT_W'(1);
            end
            if (st1_absd_reg != '0 && wrong_reg < CNT_LIMIT) begin
                wrong_next = wrong_reg + CNT_W'(1);
            end
            if (st1_absd_reg > worst_reg) begin
                worst_next = st1_absd_reg;
            end
            sum_next = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
            wt_next  = wt_add[WSUM_W] ? {WSUM_W{1'b1}} : wt_add[WSUM_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg  <= '0;
            wrong_reg <= '0;
            worst_reg <= '0;
            sum_reg   <= '0;
            wt_reg    <= '0;
        end else begin
            seen_reg  <= seen_next;
            wrong_reg <= wrong_next;
            worst_reg <= worst_next;
            sum_reg   <= sum_next;
            wt_reg    <= wt_next;
        end
    end

    assign div_num = cmd.div_sel_frac ? NUM_W'({wrong_reg, 16'b0}) : {sum_reg, 8'b0};
    assign div_den = cmd.div_sel_frac ? WSUM_W'(seen_reg) : wt_reg;

    aema_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quo     (div_quo)
    );

    always_ff @(posedge aclk) begin
        if (cmd.cap_mean && div_done) begin
            mean_reg <= div_quo;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load_sum) begin
            out_data_reg <= {seen_reg, CNT_W'(seen_reg - wrong_reg), div_quo[FRAC_W-1:0],
                             mean_reg, worst_reg, st1_diff_reg};
            out_user_reg <= 1'b1;
        end else if (cmd.out_load_item) begin
            out_data_reg <= {(M_PAYLOAD_W - DIFF_W)'(0), st1_diff_reg};
            out_user_reg <= 1'b0;
        end
    end

    assign status.st1_last = st1_last_reg;
    assign status.div_done = div_done;
    assign m_tdata         = {(M_TDATA_W - M_PAYLOAD_W)'(0), out_data_reg};
    assign m_tuser         = out_user_reg;

endmodule

// File: design/aema_ctrl.sv
// Controller: input/output handshakes, stage valid flags and the summary
// sequence through the shared divider. Uses aema_pkg.
module aema_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    input  aema_pkg::status_t   status,
    output aema_pkg::cmd_t      cmd
);
    import aema_pkg::*;

    state_t state_reg, state_next;
    logic   st1_valid_reg, st1_valid_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;
    logic   fire_item;
    logic   fire_last;

    assign out_free  = !out_valid_reg || m_tready;
    assign fire_item = (state_reg == S_RUN) && st1_valid_reg && out_free && !status.st1_last;
    assign fire_last = (state_reg == S_RUN) && st1_valid_reg && status.st1_last;
    assign s_tready  = (state_reg == S_RUN) && (!st1_valid_reg || fire_item);

    always_comb begin
        cmd               = '0;
        cmd.st1_load      = s_tvalid && s_tready;
        cmd.acc_en        = fire_item || fire_last;
        cmd.out_load_item = fire_item;
        state_next        = state_reg;
        case (state_reg)
            S_RUN: begin
                if (fire_last) begin
                    state_next = S_MEAN_GO;
                end
            end
            S_MEAN_GO: begin
                cmd.div_start = 1'b1;
                state_next    = S_MEAN_WAIT;
            end
            S_MEAN_WAIT: begin
                cmd.cap_mean = 1'b1;
                if (status.div_done) begin
                    state_next = S_FRAC_GO;
                end
            end
            S_FRAC_GO: begin
                cmd.div_start    = 1'b1;
                cmd.div_sel_frac = 1'b1;
                state_next       = S_FRAC_WAIT;
            end
            S_FRAC_WAIT: begin
                cmd.div_sel_frac = 1'b1;
                if (status.div_done) begin
                    state_next = S_SUMMARY;
                end
            end
            S_SUMMARY: begin
                if (out_free) begin
                    cmd.out_load_sum = 1'b1;
                    state_next       = S_RUN;
                end
            end
            default: begin
                state_next = S_RUN;
            end
        endcase
    end

    always_comb begin
        st1_valid_next = st1_valid_reg;
        if (cmd.st1_load) begin
            st1_valid_next = 1'b1;
        end else if (fire_item || cmd.out_load_sum) begin
            st1_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (cmd.out_load_item || cmd.out_load_sum) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_RUN;
            st1_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            st1_valid_reg <= st1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;

    // the last pattern stays staged for the whole summary sequence
    a_last_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_RUN) |-> (st1_valid_reg && status.st1_last))
        else $error("last pattern lost during summary");
    // divider completions only arrive while waiting for them
    a_done_when_waiting: assert property (@(posedge aclk) disable iff (!aresetn)
        status.div_done |-> (state_reg == S_MEAN_WAIT || state_reg == S_FRAC_WAIT))
        else $error("unexpected divider completion");
    // a loaded result never overwrites one still waiting for transfer
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.out_load_item || cmd.out_load_sum) |-> (!out_valid_reg || m_tready))
        else $error("output register overwritten");
    // a summary load clears the run, so no accumulation in the same cycle
    a_sum_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load_sum |-> !cmd.acc_en)
        else $error("accumulate during summary load");

endmodule

// File: design/approx_error_metric_accumulator_core.sv
// Top level of the approximate-circuit error metric accumulator.
// Depends on aema_pkg, aema_ctrl, aema_dp (which holds aema_div).
//
// Usage:
//   s_ channel: one pattern per transfer. s_tdata carries the exact word,
//   the approximate word and the Q0.16 weight; s_tlast marks the final
//   pattern of a run. m_ channel: one result per pattern with the signed
//   difference; m_tuser is high on the result of the last pattern, which
//   also carries worst error, Q16.8 weighted mean error, Q1.16 error rate,
//   correct count and pattern count. Running sums clear after it.
//   cfg channel: single-bit uniform_weights mode, always ready.
// Throughput: one pattern per cycle while m_tready stays high. Each result
//   passes through the input stage register and then the output register.
//   The last pattern of a run runs two passes of the 24-step shared
//   restoring divider (mean, then rate) before its result is loaded,
//   and s_tready stays low until then.
// Reset: aresetn low clears all sums and counts, drops both valids and sets
//   uniform_weights to 1.
// Stall: with m_tready low the output register holds its result; one more
//   pattern is staged, then s_tready drops until the result is taken.
module approx_error_metric_accumulator_core #(
    parameter int OUTPUT_BITS    = aema_pkg::OUTPUT_BITS,
    parameter int MAX_INPUT_VARS = aema_pkg::MAX_INPUT_VARS
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [15:0] exact_value, [31:16] approx_value, [47:32] weight
    input  logic [aema_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                           s_tlast,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [16:0] difference, [32:17] worst_error, [56:33] mean_error,
    // [73:57] wrong_fraction, [90:74] correct_count, [107:91] pattern_count
    output logic [aema_pkg::M_TDATA_W-1:0] m_tdata,
    // [0] summary_valid
    output logic                           m_tuser,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic                           cfg_data
);
    import aema_pkg::*;

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    aema_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    aema_dp #(
        .OUTPUT_BITS    (OUTPUT_BITS),
        .MAX_INPUT_VARS (MAX_INPUT_VARS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule
